// ===== rtl/core/mp3_player_command_controller_core_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef MP3_PLAYER_COMMAND_CONTROLLER_CORE_MACROS_SVH
`define MP3_PLAYER_COMMAND_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mpcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mpcc assertion failed");

`endif

// ===== rtl/core/mpcc_pkg.sv =====
`default_nettype none

package mpcc_pkg;

    // Event codes carried in the func field.
    typedef enum logic [3:0] {
        FUNC_INIT       = 4'd0,
        FUNC_PLAY_PAUSE = 4'd1,
        FUNC_NEXT       = 4'd2,
        FUNC_PREV       = 4'd3,
        FUNC_VOL_UP     = 4'd4,
        FUNC_VOL_DOWN   = 4'd5,
        FUNC_RANDOM     = 4'd6,
        FUNC_SELECT     = 4'd7,
        FUNC_BUSY       = 4'd8
    } func_code_t;

    typedef struct packed {
        logic [3:0]  func;
        logic        busy_level;
        logic [11:0] track_choice;
        logic [15:0] random_value;
    } mpcc_in_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic [11:0] track_now;
        logic [4:0]  volume_now;
        logic        paused_now;
    } mpcc_out_t;

    // Frame framing bytes and player commands.
    localparam logic [7:0] FRAME_START   = 8'h7E;
    localparam logic [7:0] FRAME_VERSION = 8'hFF;
    localparam logic [7:0] FRAME_LENGTH  = 8'h06;
    localparam logic [7:0] FRAME_END     = 8'hEF;
    localparam logic [7:0] CMD_VOLUME    = 8'h06;
    localparam logic [7:0] CMD_PAUSE     = 8'h0E;
    localparam logic [7:0] CMD_RESUME    = 8'h0D;
    localparam logic [7:0] CMD_PLAY      = 8'h12;
    localparam logic [7:0] CMD_STOP      = 8'h16;

    localparam logic [4:0]  VOL_MAX        = 5'd30;
    localparam logic [4:0]  VOL_STEP       = 5'd5;
    localparam logic [4:0]  VOL_RESET      = 5'd5;
    localparam logic [11:0] TRACK_RESET    = 12'd1;
    localparam logic [11:0] TRACK_CNT_RESET = 12'd4;
    localparam logic [3:0]  FRAME_LAST_IDX = 4'd9;
    localparam logic [3:0]  DIV_LAST_STEP  = 4'd15;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EXEC,
        OP_EMIT,
        OP_NEXT_FRAME
    } uop_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_VALID,
        COND_NOT_RANDOM,
        COND_DIV_MORE,
        COND_NO_FRAME,
        COND_BYTE_MORE,
        COND_TWO_FRAMES
    } uop_cond_t;

    typedef struct packed {
        uop_op_t    op;
        uop_cond_t  cond;
        logic [2:0] target;
    } uop_t;

    // Microprogram: one control word per step, jump taken when cond holds.
    localparam uop_t UCODE [8] = '{
        '{op: OP_ACCEPT,     cond: COND_NOT_VALID,  target: 3'd0},
        '{op: OP_DIV_INIT,   cond: COND_NOT_RANDOM, target: 3'd3},
        '{op: OP_DIV_STEP,   cond: COND_DIV_MORE,   target: 3'd2},
        '{op: OP_EXEC,       cond: COND_NO_FRAME,   target: 3'd0},
        '{op: OP_EMIT,       cond: COND_BYTE_MORE,  target: 3'd4},
        '{op: OP_NEXT_FRAME, cond: COND_TWO_FRAMES, target: 3'd4},
        '{op: OP_NONE,       cond: COND_ALWAYS,     target: 3'd0},
        '{op: OP_NONE,       cond: COND_ALWAYS,     target: 3'd0}
    };

endpackage

`default_nettype wire

// ===== rtl/core/mp3_player_command_controller_core.sv =====
// Command controller for a serial MP3 player module.
// The s_ channel takes one event word (func, busy_level, track_choice,
// random_value); the m_ channel gives out the command frame bytes it causes,
// one byte per word, with last_byte set on the final byte of the event and
// the track, volume and paused state after the event on every byte.
// An event yields none, one or two 10-byte frames (init gives two).
// Events are taken one at a time: s_ready is high only while the sequencer
// waits on its accept step. After acceptance the exec step computes the new
// state and the emit step then loads the first byte into the output register;
// a random event first passes a restoring divider that retires one quotient
// bit per cycle, and its remainder gives the track. The emit step sends the
// bytes of each frame in order, then the sequencer returns to its accept step.
// A single output register holds the current byte; when the receiver
// stalls the sequencer holds on its emit step and no byte is lost.
// cfg_wr_en registers cfg_wr_data into track_count (reset value 4).
// Reset (aresetn low, synchronous) restores track 1, volume 5, not paused,
// last busy level 1, and empties the output register.
`default_nettype none

module mp3_player_command_controller_core
    import mpcc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [11:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire mpcc_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output mpcc_out_t       m_data
);

    typedef struct packed {
        logic [11:0] track;
        logic [4:0]  volume;
        logic        paused;
        logic        last_busy;
        logic        frame;
        logic        two;
        logic [7:0]  cmd;
        logic [7:0]  p1;
        logic [7:0]  p2;
    } exec_t;

    logic [2:0]  pc_reg, pc_next;
    uop_t        uop;

    logic [11:0] track_count_reg;
    logic [11:0] track_reg;
    logic [4:0]  volume_reg;
    logic        paused_reg;
    logic        last_busy_reg;

    mpcc_in_t    in_reg;
    logic [15:0] dvd_reg;
    logic [11:0] rem_reg, rem_next;
    logic [3:0]  div_cnt_reg;

    logic [7:0]  cmd_reg, p1_reg, p2_reg;
    logic        two_reg;
    logic [3:0]  byte_idx_reg;

    logic        m_valid_reg;
    mpcc_out_t   m_data_reg;

    logic [11:0] count_eff;
    logic [12:0] rem_shift;
    exec_t       ex;
    logic        out_free;
    logic        hold;
    logic        jump;
    logic [15:0] chk_sum;
    logic [15:0] chk;
    logic [7:0]  cur_byte;

    assign uop       = UCODE[pc_reg];
    assign count_eff = (track_count_reg == 12'd0) ? 12'd1 : track_count_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign hold      = (uop.op == OP_EMIT) && !out_free;
    assign s_ready   = (uop.op == OP_ACCEPT);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // One restoring division step: the remainder stays below count_eff.
    assign rem_shift = {rem_reg, dvd_reg[15]};
    assign rem_next  = (rem_shift >= {1'b0, count_eff})
                     ? 12'(rem_shift - {1'b0, count_eff}) : rem_shift[11:0];

    always_comb begin
        logic [12:0] nxt;
        logic [11:0] nxt_track;
        logic [5:0]  vol_up;
        nxt       = {1'b0, track_reg} + 13'd1;
        nxt_track = (nxt > {1'b0, count_eff}) ? 12'd1 : nxt[11:0];
        vol_up    = {1'b0, volume_reg} + {1'b0, VOL_STEP};
        ex.track     = track_reg;
        ex.volume    = volume_reg;
        ex.paused    = paused_reg;
        ex.last_busy = last_busy_reg;
        ex.frame     = 1'b0;
        ex.two       = 1'b0;
        ex.cmd       = CMD_PLAY;
        ex.p1        = 8'h00;
        ex.p2        = 8'h00;
        case (in_reg.func)
            FUNC_INIT: begin
                ex.frame  = 1'b1;
                ex.two    = 1'b1;
                ex.cmd    = CMD_VOLUME;
                ex.p2     = {3'b000, volume_reg};
                ex.track  = TRACK_RESET;
                ex.paused = 1'b0;
            end
            FUNC_PLAY_PAUSE: begin
                ex.frame = 1'b1;
                if (in_reg.busy_level && !paused_reg) begin
                    ex.cmd = CMD_PLAY;
                end else if (!in_reg.busy_level && !paused_reg) begin
                    ex.cmd    = CMD_PAUSE;
                    ex.paused = 1'b1;
                end else begin
                    ex.cmd    = CMD_RESUME;
                    ex.paused = 1'b0;
                end
            end
            FUNC_NEXT: begin
                ex.frame = 1'b1;
                ex.track = nxt_track;
            end
            FUNC_PREV: begin
                ex.frame = 1'b1;
                ex.track = (track_reg <= 12'd1) ? count_eff : 12'(track_reg - 12'd1);
            end
            FUNC_VOL_UP: begin
                if (volume_reg < VOL_MAX) begin
                    ex.frame  = 1'b1;
                    ex.cmd    = CMD_VOLUME;
                    ex.volume = (vol_up > {1'b0, VOL_MAX}) ? VOL_MAX : vol_up[4:0];
                    ex.p2     = {3'b000, ex.volume};
                end
            end
            FUNC_VOL_DOWN: begin
                if (volume_reg != 5'd0) begin
                    ex.frame  = 1'b1;
                    ex.cmd    = CMD_VOLUME;
                    ex.volume = (volume_reg < VOL_STEP) ? 5'd0
                              : 5'(volume_reg - VOL_STEP);
                    ex.p2     = {3'b000, ex.volume};
                end
            end
            FUNC_RANDOM: begin
                ex.frame = 1'b1;
                ex.track = 12'(rem_reg + 12'd1);
            end
            FUNC_SELECT: begin
                ex.frame = 1'b1;
                ex.track = (in_reg.track_choice >= count_eff) ? count_eff
                         : 12'(in_reg.track_choice + 12'd1);
            end
            FUNC_BUSY: begin
                if (!last_busy_reg && in_reg.busy_level && !paused_reg) begin
                    ex.frame = 1'b1;
                    ex.track = nxt_track;
                end
                ex.last_busy = in_reg.busy_level;
            end
            default: begin
                ex.frame = 1'b0;
            end
        endcase
        // Every play command carries the new track and clears the pause.
        if (ex.frame && ex.cmd == CMD_PLAY) begin
            ex.p1     = {4'h0, ex.track[11:8]};
            ex.p2     = ex.track[7:0];
            ex.paused = 1'b0;
        end
    end

    assign chk_sum = 16'(FRAME_VERSION) + 16'(FRAME_LENGTH) + 16'(cmd_reg)
                   + 16'(p1_reg) + 16'(p2_reg);
    assign chk     = 16'(16'd0 - chk_sum);

    always_comb begin
        case (byte_idx_reg)
            4'd0:    cur_byte = FRAME_START;
            4'd1:    cur_byte = FRAME_VERSION;
            4'd2:    cur_byte = FRAME_LENGTH;
            4'd3:    cur_byte = cmd_reg;
            4'd4:    cur_byte = 8'h00;
            4'd5:    cur_byte = p1_reg;
            4'd6:    cur_byte = p2_reg;
            4'd7:    cur_byte = chk[15:8];
            4'd8:    cur_byte = chk[7:0];
            default: cur_byte = FRAME_END;
        endcase
    end

    always_comb begin
        case (uop.cond)
            COND_NEVER:      jump = 1'b0;
            COND_ALWAYS:     jump = 1'b1;
            COND_NOT_VALID:  jump = !s_valid;
            COND_NOT_RANDOM: jump = (in_reg.func != FUNC_RANDOM);
            COND_DIV_MORE:   jump = (div_cnt_reg != DIV_LAST_STEP);
            COND_NO_FRAME:   jump = !ex.frame;
            COND_BYTE_MORE:  jump = (byte_idx_reg != FRAME_LAST_IDX);
            COND_TWO_FRAMES: jump = two_reg;
            default:         jump = 1'b0;
        endcase
        if (hold) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = uop.target;
        end else begin
            pc_next = 3'(pc_reg + 3'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= 3'd0;
            track_count_reg <= TRACK_CNT_RESET;
            track_reg       <= TRACK_RESET;
            volume_reg      <= VOL_RESET;
            paused_reg      <= 1'b0;
            last_busy_reg   <= 1'b1;
            two_reg         <= 1'b0;
            byte_idx_reg    <= 4'd0;
            div_cnt_reg     <= 4'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (cfg_wr_en) begin
                track_count_reg <= cfg_wr_data;
            end
            // On the emit step the output register is refilled whenever it is free.
            if (m_valid_reg && m_ready && uop.op != OP_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (uop.op)
                OP_ACCEPT: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                    end
                end
                OP_DIV_INIT: begin
                    dvd_reg     <= in_reg.random_value;
                    rem_reg     <= 12'd0;
                    div_cnt_reg <= 4'd0;
                end
                OP_DIV_STEP: begin
                    dvd_reg     <= {dvd_reg[14:0], 1'b0};
                    rem_reg     <= rem_next;
                    div_cnt_reg <= 4'(div_cnt_reg + 4'd1);
                end
                OP_EXEC: begin
                    track_reg     <= ex.track;
                    volume_reg    <= ex.volume;
                    paused_reg    <= ex.paused;
                    last_busy_reg <= ex.last_busy;
                    two_reg       <= ex.two;
                    cmd_reg       <= ex.cmd;
                    p1_reg        <= ex.p1;
                    p2_reg        <= ex.p2;
                    byte_idx_reg  <= 4'd0;
                end
                OP_EMIT: begin
                    if (out_free) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.frame_byte <= cur_byte;
                        m_data_reg.last_byte  <= (byte_idx_reg == FRAME_LAST_IDX)
                                                 && !two_reg;
                        m_data_reg.track_now  <= track_reg;
                        m_data_reg.volume_now <= volume_reg;
                        m_data_reg.paused_now <= paused_reg;
                        byte_idx_reg <= (byte_idx_reg == FRAME_LAST_IDX) ? 4'd0
                                      : 4'(byte_idx_reg + 4'd1);
                    end
                end
                OP_NEXT_FRAME: begin
                    // Only init sends a second frame: the stop command.
                    if (two_reg) begin
                        two_reg <= 1'b0;
                        cmd_reg <= CMD_STOP;
                        p1_reg  <= 8'h00;
                        p2_reg  <= 8'h00;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mpcc_checker.sv =====
`default_nettype none
`include "mp3_player_command_controller_core_macros.svh"

module mpcc_checker
    import mpcc_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire mpcc_out_t m_data
);

    // A stalled word must stay on the result channel unchanged.
    `MPCC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // Events are handled one at a time, so no accept follows directly on another.
    `MPCC_ASSERT_NEXT(a_no_back_to_back, s_valid && s_ready, !s_ready)

    // The last byte of an event is always the end-of-frame byte.
    `MPCC_ASSERT_NOW(a_last_is_end, m_valid && m_data.last_byte,
        m_data.frame_byte == FRAME_END)

    // Reported volume stays at or below VOL_MAX and the reported track is never zero.
    `MPCC_ASSERT_NOW(a_state_range, m_valid,
        m_data.volume_now <= VOL_MAX && m_data.track_now != 12'd0)

endmodule

bind mp3_player_command_controller_core mpcc_checker u_mpcc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
